// ===== src/rrwt_pkg.sv =====
`timescale 1ns / 1ps

package rrwt_pkg;

    localparam int SLICE_W      = 16;
    localparam int IN_BURST_W   = 16;
    localparam int IDX_W        = 6;
    localparam int WAIT_W       = 22;
    localparam int TOT_W        = 28;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 112;
    localparam int OUT_PAD_W    = OUT_TDATA_W - (IDX_W + 2 * WAIT_W + 2 * TOT_W);

    localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(4);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED_RD,
        ST_SCHED_EX,
        ST_OUT_RD,
        ST_OUT_EX,
        ST_OUT_HOLD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // store one burst
        logic step;     // run one job of the current pass
        logic emit;     // build one result
        logic advance;  // result taken, move on
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full_next;  // this load fills the store
        logic idx_last;   // pointer on last job of batch
        logic busy_any;   // some job ran in this pass
    } t_stat;

endpackage

// ===== src/rrwt_ctrl.sv =====
`timescale 1ns / 1ps

module rrwt_ctrl
    import rrwt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_last,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_ready,
    output logic  o_out_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && (i_in_last || i_stat.full_next)) begin
                    n_state = ST_SCHED_RD;
                end
            end
            ST_SCHED_RD: begin
                n_state = ST_SCHED_EX;
            end
            ST_SCHED_EX: begin
                if (i_stat.idx_last && !i_stat.busy_any) begin
                    n_state = ST_OUT_RD;
                end else begin
                    n_state = ST_SCHED_RD;
                end
            end
            ST_OUT_RD: begin
                n_state = ST_OUT_EX;
            end
            ST_OUT_EX: begin
                n_state = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (i_out_ready) begin
                    n_state = i_stat.idx_last ? ST_IDLE : ST_OUT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SCHED_EX: begin
                o_cmd.step = 1'b1;
            end
            ST_OUT_EX: begin
                o_cmd.emit = 1'b1;
            end
            ST_OUT_HOLD: begin
                o_out_valid   = 1'b1;
                o_cmd.advance = i_out_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/rrwt_datapath.sv =====
`timescale 1ns / 1ps

module rrwt_datapath
    import rrwt_pkg::*;
#(
    parameter int MAX_JOBS   = 64,
    parameter int BURST_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [SLICE_W-1:0]    i_cfg_wdata,
    input  logic [IN_BURST_W-1:0] i_burst,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic [IDX_W-1:0]      o_job_index,
    output logic [WAIT_W-1:0]     o_waiting,
    output logic [WAIT_W-1:0]     o_turnaround,
    output logic [TOT_W-1:0]      o_total_waiting,
    output logic [TOT_W-1:0]      o_total_turnaround,
    output logic                  o_last_result
);

    localparam int ADDR_W = $clog2(MAX_JOBS);
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int CMP_W  = (BURST_BITS > SLICE_W) ? BURST_BITS : SLICE_W;

    logic [BURST_BITS-1:0] mem_orig [MAX_JOBS];
    logic [BURST_BITS-1:0] mem_rem  [MAX_JOBS];
    logic [WAIT_W-1:0]     mem_wait [MAX_JOBS];

    logic [CNT_W-1:0]      r_count;
    logic [ADDR_W-1:0]     r_idx;
    logic                  r_busy;
    logic [SLICE_W-1:0]    r_slice;
    logic [WAIT_W-1:0]     r_clock;
    logic [TOT_W-1:0]      r_tw;
    logic [TOT_W-1:0]      r_tt;
    logic [BURST_BITS-1:0] r_orig_q;
    logic [BURST_BITS-1:0] r_rem_q;
    logic [WAIT_W-1:0]     r_wait_q;

    logic [IDX_W-1:0]      r_out_idx;
    logic [WAIT_W-1:0]     r_out_w;
    logic [WAIT_W-1:0]     r_out_t;
    logic [TOT_W-1:0]      r_out_tw;
    logic [TOT_W-1:0]      r_out_tt;
    logic                  r_out_last;

    logic [ADDR_W-1:0]     wr_addr;
    logic [BURST_BITS-1:0] load_burst;
    logic [CMP_W-1:0]      quantum;
    logic [CMP_W-1:0]      rem_ext;
    logic                  active;
    logic                  finish;
    logic [CMP_W-1:0]      run_time;
    logic [BURST_BITS-1:0] n_rem;
    logic [WAIT_W-1:0]     n_clock;
    logic [WAIT_W-1:0]     n_wait;
    logic [WAIT_W-1:0]     turn;
    logic [31:0]           idx_ext;

    assign wr_addr    = i_cmd.load ? r_count[ADDR_W-1:0] : r_idx;
    assign load_burst = BURST_BITS'(i_burst);

    // zero slice behaves as one
    assign quantum  = (r_slice == '0) ? CMP_W'(1) : CMP_W'(r_slice);
    assign rem_ext  = CMP_W'(r_rem_q);
    assign active   = (r_rem_q != '0);
    assign finish   = (rem_ext <= quantum);
    assign run_time = finish ? rem_ext : quantum;
    assign n_rem    = finish ? '0 : BURST_BITS'(rem_ext - quantum);
    assign n_clock  = r_clock + WAIT_W'(run_time);
    assign n_wait   = n_clock - WAIT_W'(r_orig_q);

    assign turn     = (r_orig_q == '0) ? '0 : WAIT_W'(r_orig_q) + r_wait_q;
    assign idx_ext  = 32'(r_idx);

    assign o_stat.full_next = (r_count == CNT_W'(MAX_JOBS - 1));
    assign o_stat.idx_last  = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign o_stat.busy_any  = r_busy | active;

    // memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem_orig[wr_addr] <= load_burst;
        end
        r_orig_q <= mem_orig[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || (i_cmd.step && active)) begin
            mem_rem[wr_addr] <= i_cmd.load ? load_burst : n_rem;
        end
        r_rem_q <= mem_rem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || (i_cmd.step && active && finish)) begin
            mem_wait[wr_addr] <= i_cmd.load ? '0 : n_wait;
        end
        r_wait_q <= mem_wait[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_busy  <= 1'b0;
            r_slice <= SLICE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_slice <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_count <= r_count + CNT_W'(1);
                r_idx   <= '0;
                r_busy  <= 1'b0;
            end else if (i_cmd.step) begin
                if (o_stat.idx_last) begin
                    r_idx  <= '0;
                    r_busy <= 1'b0;
                end else begin
                    r_idx  <= r_idx + ADDR_W'(1);
                    r_busy <= o_stat.busy_any;
                end
            end else if (i_cmd.advance) begin
                if (o_stat.idx_last) begin
                    r_idx   <= '0;
                    r_count <= '0;
                end else begin
                    r_idx <= r_idx + ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_clock <= '0;
            r_tw    <= '0;
            r_tt    <= '0;
        end else if (i_cmd.step && active) begin
            r_clock <= n_clock;
        end else if (i_cmd.emit) begin
            r_tw <= r_tw + TOT_W'(r_wait_q);
            r_tt <= r_tt + TOT_W'(turn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_idx  <= idx_ext[IDX_W-1:0];
            r_out_w    <= r_wait_q;
            r_out_t    <= turn;
            r_out_tw   <= r_tw + TOT_W'(r_wait_q);
            r_out_tt   <= r_tt + TOT_W'(turn);
            r_out_last <= o_stat.idx_last;
        end
    end

    assign o_job_index        = r_out_idx;
    assign o_waiting          = r_out_w;
    assign o_turnaround       = r_out_t;
    assign o_total_waiting    = r_out_tw;
    assign o_total_turnaround = r_out_tt;
    assign o_last_result      = r_out_last;

endmodule

// ===== src/round_robin_wait_time_unit.sv =====
`timescale 1ns / 1ps

// Round-robin wait time unit. Burst times come in one request per cycle and
// are kept in on-chip memory; the request marked tlast, or the one that fills
// the store of MAX_JOBS entries, starts scheduling. Scheduling walks the
// stored jobs in load order, pass after pass, with a registered memory read
// and then an update for each job in each pass, until a pass in which no
// job ran. Results then leave in load order, one at a time; each is read
// from the job memories, built in the result register and held until taken.
// New bursts are taken only when no batch is in flight. The slice register
// may be written only while the unit is idle; a zero slice counts as one.

module round_robin_wait_time_unit
    import rrwt_pkg::*;
#(
    parameter int MAX_JOBS   = 64,
    parameter int BURST_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // time slice register
    input  logic                   i_cfg_we,
    input  logic [SLICE_W-1:0]     i_cfg_wdata,
    // burst requests
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] burst_time
    input  logic                   s_axis_tlast,   // last_job
    // per-job results
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [5:0] job_index, [27:6] waiting_time, [49:28] turnaround_time,
    // [77:50] total_waiting, [105:78] total_turnaround, [111:106] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast    // last_result
);

    t_cmd              cmd;
    t_stat             stat;
    logic [IDX_W-1:0]  job_index;
    logic [WAIT_W-1:0] waiting;
    logic [WAIT_W-1:0] turnaround;
    logic [TOT_W-1:0]  total_waiting;
    logic [TOT_W-1:0]  total_turnaround;

    // sequencing: load, scheduling passes, result drain
    rrwt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    // job memories, clock, totals and result register
    rrwt_datapath #(
        .MAX_JOBS   (MAX_JOBS),
        .BURST_BITS (BURST_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_burst            (s_axis_tdata),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_job_index        (job_index),
        .o_waiting          (waiting),
        .o_turnaround       (turnaround),
        .o_total_waiting    (total_waiting),
        .o_total_turnaround (total_turnaround),
        .o_last_result      (m_axis_tlast)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, total_turnaround, total_waiting,
                           turnaround, waiting, job_index};

endmodule

// ===== src/rrwt_checker.sv =====
`timescale 1ns / 1ps

module rrwt_checker
    import rrwt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tlast,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // no new request while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken during result drain");

    // closing request starts scheduling
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("request taken after batch close");

    // final result ends the batch
    a_batch_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
        else $error("batch did not end after final result");

endmodule

bind round_robin_wait_time_unit rrwt_checker u_rrwt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
